// ===== rtl/core/mfde_pkg.sv =====
// Shared types, constants and helpers for the monochrome frame-store draw engine.
// Depends on nothing; the clip, engine and top-level files refer to it by scoped names.
`default_nettype none

package mfde_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int ROW_BYTES     = (SCREEN_WIDTH + 7) / 8;
    localparam int STORE_BYTES   = ROW_BYTES * SCREEN_HEIGHT;
    localparam int ADDR_W        = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    localparam int COORD_W  = 10;
    localparam int BYTE_W   = COORD_W - 3;
    localparam int BOX_W    = COORD_W + 1;
    localparam int EXT_W    = COORD_W + 2;
    localparam int CFG_IDX_W = 3;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 8;

    localparam logic [2:0] OP_PIXEL   = 3'd0;
    localparam logic [2:0] OP_HSPAN   = 3'd1;
    localparam logic [2:0] OP_VSPAN   = 3'd2;
    localparam logic [2:0] OP_RECT    = 3'd3;
    localparam logic [2:0] OP_OUTLINE = 3'd4;
    localparam logic [2:0] OP_READ    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y_MAX  = 3'd4;

    typedef struct packed {
        logic               clip_enable;
        logic [COORD_W-1:0] clip_x_min;
        logic [COORD_W-1:0] clip_x_max;
        logic [COORD_W-1:0] clip_y_min;
        logic [COORD_W-1:0] clip_y_max;
    } clip_cfg_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] span_w;
        logic [COORD_W-1:0] span_h;
        logic               ink;
    } cmd_t;

    typedef struct packed {
        logic [BOX_W-1:0] x0;
        logic [BOX_W-1:0] y0;
        logic [BOX_W-1:0] w;
        logic [BOX_W-1:0] h;
    } box_t;

    typedef struct packed {
        logic               empty;
        logic [COORD_W-1:0] col_lo;
        logic [COORD_W-1:0] col_hi;
        logic [COORD_W-1:0] row_lo;
        logic [COORD_W-1:0] row_hi;
    } range_t;

    // Pixel mask of one byte covering bit positions first .. last, leftmost pixel in bit 7.
    function automatic logic [7:0] byte_mask(input logic [2:0] first, input logic [2:0] last);
        logic [7:0] lo_part;
        logic [7:0] hi_part;
        lo_part = 8'hFF >> first;
        hi_part = 8'hFF << (3'd7 - last);
        return lo_part & hi_part;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mfde_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; it is used for the frame store of the draw engine.
`default_nettype none

module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mfde_clip.sv =====
// Clips one box against the screen and the optional clip window into inclusive ranges.
// Depends on mfde_pkg for the box, range and configuration types.
`default_nettype none

module mfde_clip (
    input  wire mfde_pkg::box_t     box,
    input  wire mfde_pkg::clip_cfg_t cfg,
    output mfde_pkg::range_t        rng
);

    logic [mfde_pkg::EXT_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic [mfde_pkg::EXT_W-1:0] x_end, y_end;
    logic [mfde_pkg::EXT_W-1:0] cx_min, cx_lim, cy_min, cy_lim;

    always_comb begin
        x_end  = mfde_pkg::EXT_W'(box.x0) + mfde_pkg::EXT_W'(box.w);
        y_end  = mfde_pkg::EXT_W'(box.y0) + mfde_pkg::EXT_W'(box.h);
        cx_min = mfde_pkg::EXT_W'(cfg.clip_x_min);
        cy_min = mfde_pkg::EXT_W'(cfg.clip_y_min);
        cx_lim = mfde_pkg::EXT_W'(cfg.clip_x_max) + mfde_pkg::EXT_W'(1);
        cy_lim = mfde_pkg::EXT_W'(cfg.clip_y_max) + mfde_pkg::EXT_W'(1);

        x_lo = mfde_pkg::EXT_W'(box.x0);
        y_lo = mfde_pkg::EXT_W'(box.y0);
        x_hi = (x_end < mfde_pkg::EXT_W'(mfde_pkg::SCREEN_WIDTH)) ?
               x_end : mfde_pkg::EXT_W'(mfde_pkg::SCREEN_WIDTH);
        y_hi = (y_end < mfde_pkg::EXT_W'(mfde_pkg::SCREEN_HEIGHT)) ?
               y_end : mfde_pkg::EXT_W'(mfde_pkg::SCREEN_HEIGHT);

        if (cfg.clip_enable) begin
            if (cx_min > x_lo) x_lo = cx_min;
            if (cy_min > y_lo) y_lo = cy_min;
            if (cx_lim < x_hi) x_hi = cx_lim;
            if (cy_lim < y_hi) y_hi = cy_lim;
        end

        rng.empty  = (x_lo >= x_hi) || (y_lo >= y_hi);
        rng.col_lo = mfde_pkg::COORD_W'(x_lo);
        rng.col_hi = mfde_pkg::COORD_W'(x_hi - mfde_pkg::EXT_W'(1));
        rng.row_lo = mfde_pkg::COORD_W'(y_lo);
        rng.row_hi = mfde_pkg::COORD_W'(y_hi - mfde_pkg::EXT_W'(1));
    end

endmodule

`default_nettype wire

// ===== rtl/core/mfde_engine.sv =====
// Command sequencer of the draw engine: clearing pass, box walk, byte read-modify-write and byte reads.
// Depends on mfde_pkg, mfde_ram for the frame store and mfde_clip for box clipping.
`default_nettype none

module mfde_engine (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire mfde_pkg::clip_cfg_t cfg,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire mfde_pkg::cmd_t      cmd,
    output logic                     res_valid,
    input  wire logic                res_ready,
    output logic [7:0]               res_data
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_BOX    = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_READ   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    localparam logic [1:0] BOX_TOP    = 2'd0;
    localparam logic [1:0] BOX_BOTTOM = 2'd1;
    localparam logic [1:0] BOX_LEFT   = 2'd2;
    localparam logic [1:0] BOX_RIGHT  = 2'd3;

    localparam int AW = mfde_pkg::ADDR_W;
    localparam int AXW = mfde_pkg::ADDR_W + mfde_pkg::COORD_W;

    logic [2:0] state_reg, state_next;
    logic [1:0] box_idx_reg, box_idx_next;
    mfde_pkg::cmd_t cmd_reg, cmd_next;
    logic [mfde_pkg::COORD_W-1:0] row_reg, row_next, row_last_reg, row_last_next;
    logic [mfde_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic [mfde_pkg::BYTE_W-1:0] byte_first_reg, byte_first_next;
    logic [mfde_pkg::BYTE_W-1:0] byte_last_reg, byte_last_next;
    logic [2:0] bit_first_reg, bit_first_next, bit_last_reg, bit_last_next;
    logic [AW-1:0] row_base_reg, row_base_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          p_valid_reg, p_valid_next;
    logic [AW-1:0] p_addr_reg, p_addr_next;
    logic [7:0]    p_mask_reg, p_mask_next;
    logic [7:0]    result_reg, result_next;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;

    mfde_pkg::box_t   box;
    mfde_pkg::range_t rng;

    logic          box_last;
    logic          cmd_on_screen;
    logic [AW-1:0] cmd_read_addr;
    logic [AW-1:0] walk_addr;
    logic [7:0]    walk_mask;
    logic [2:0]    mask_first, mask_last;
    logic [mfde_pkg::BOX_W-1:0] bx, by, bw, bh;

    mfde_ram #(
        .WIDTH(8),
        .DEPTH(mfde_pkg::STORE_BYTES)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    mfde_clip u_clip (
        .box(box),
        .cfg(cfg),
        .rng(rng)
    );

    // An outline is split into four boxes; the other shapes are one box each.
    always_comb begin
        bx = mfde_pkg::BOX_W'(cmd_reg.pos_x);
        by = mfde_pkg::BOX_W'(cmd_reg.pos_y);
        bw = mfde_pkg::BOX_W'(cmd_reg.span_w);
        bh = mfde_pkg::BOX_W'(cmd_reg.span_h);
        box = '{x0: bx, y0: by, w: mfde_pkg::BOX_W'(1), h: mfde_pkg::BOX_W'(1)};
        unique case (cmd_reg.opcode)
            mfde_pkg::OP_HSPAN: box.w = bw;
            mfde_pkg::OP_VSPAN: box.h = bh;
            mfde_pkg::OP_RECT: begin
                box.w = bw;
                box.h = bh;
            end
            mfde_pkg::OP_OUTLINE: begin
                unique case (box_idx_reg)
                    BOX_TOP: box.w = bw + mfde_pkg::BOX_W'(1);
                    BOX_BOTTOM: begin
                        box.y0 = by + bh;
                        box.w  = bw + mfde_pkg::BOX_W'(1);
                    end
                    BOX_LEFT: box.h = bh + mfde_pkg::BOX_W'(1);
                    BOX_RIGHT: begin
                        box.x0 = bx + bw;
                        box.h  = bh + mfde_pkg::BOX_W'(1);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        box_last = (cmd_reg.opcode != mfde_pkg::OP_OUTLINE) || (box_idx_reg == BOX_RIGHT);
        cmd_on_screen =
            ({1'b0, cmd.pos_x} < (mfde_pkg::COORD_W + 1)'(mfde_pkg::SCREEN_WIDTH)) &&
            ({1'b0, cmd.pos_y} < (mfde_pkg::COORD_W + 1)'(mfde_pkg::SCREEN_HEIGHT));
        cmd_read_addr = AW'(int'(cmd.pos_y) * mfde_pkg::ROW_BYTES + int'(cmd.pos_x >> 3));
        walk_addr  = AW'(AXW'(row_base_reg) + AXW'(byte_reg));
        mask_first = (byte_reg == byte_first_reg) ? bit_first_reg : 3'd0;
        mask_last  = (byte_reg == byte_last_reg) ? bit_last_reg : 3'd7;
        walk_mask  = mfde_pkg::byte_mask(mask_first, mask_last);
    end

    always_comb begin
        state_next      = state_reg;
        box_idx_next    = box_idx_reg;
        cmd_next        = cmd_reg;
        row_next        = row_reg;
        row_last_next   = row_last_reg;
        byte_next       = byte_reg;
        byte_first_next = byte_first_reg;
        byte_last_next  = byte_last_reg;
        bit_first_next  = bit_first_reg;
        bit_last_next   = bit_last_reg;
        row_base_next   = row_base_reg;
        clr_addr_next   = clr_addr_reg;
        p_valid_next    = 1'b0;
        p_addr_next     = p_addr_reg;
        p_mask_next     = p_mask_reg;
        result_next     = result_reg;
        cmd_ready       = 1'b0;
        res_valid       = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = walk_addr;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(mfde_pkg::STORE_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next     = cmd;
                    box_idx_next = BOX_TOP;
                    result_next  = 8'd0;
                    unique case (cmd.opcode)
                        mfde_pkg::OP_PIXEL, mfde_pkg::OP_HSPAN, mfde_pkg::OP_VSPAN,
                        mfde_pkg::OP_RECT, mfde_pkg::OP_OUTLINE: begin
                            state_next = ST_BOX;
                        end
                        mfde_pkg::OP_READ: begin
                            if (cmd_on_screen) begin
                                rd_en      = 1'b1;
                                rd_addr    = cmd_read_addr;
                                state_next = ST_READ;
                            end else begin
                                state_next = ST_FINISH;
                            end
                        end
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_BOX: begin
                if (rng.empty) begin
                    if (box_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        box_idx_next = box_idx_reg + 2'd1;
                    end
                end else begin
                    row_next        = rng.row_lo;
                    row_last_next   = rng.row_hi;
                    byte_first_next = rng.col_lo[mfde_pkg::COORD_W-1:3];
                    byte_last_next  = rng.col_hi[mfde_pkg::COORD_W-1:3];
                    byte_next       = rng.col_lo[mfde_pkg::COORD_W-1:3];
                    bit_first_next  = rng.col_lo[2:0];
                    bit_last_next   = rng.col_hi[2:0];
                    row_base_next   = AW'(int'(rng.row_lo) * mfde_pkg::ROW_BYTES);
                    state_next      = ST_WALK;
                end
            end
            ST_WALK: begin
                rd_en        = 1'b1;
                p_valid_next = 1'b1;
                p_addr_next  = walk_addr;
                p_mask_next  = walk_mask;
                if (byte_reg != byte_last_reg) begin
                    byte_next = byte_reg + mfde_pkg::BYTE_W'(1);
                end else if (row_reg != row_last_reg) begin
                    row_next      = row_reg + mfde_pkg::COORD_W'(1);
                    row_base_next = row_base_reg + AW'(mfde_pkg::ROW_BYTES);
                    byte_next     = byte_first_reg;
                end else if (box_last) begin
                    state_next = ST_FINISH;
                end else begin
                    box_idx_next = box_idx_reg + 2'd1;
                    state_next   = ST_BOX;
                end
            end
            ST_READ: begin
                result_next = rd_data;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        priority if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = 8'd0;
        end else begin
            wr_en   = p_valid_reg;
            wr_addr = p_addr_reg;
            wr_data = cmd_reg.ink ? (rd_data | p_mask_reg) : (rd_data & ~p_mask_reg);
        end
    end

    assign res_data = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            p_valid_reg  <= 1'b0;
            box_idx_reg  <= BOX_TOP;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            p_valid_reg  <= p_valid_next;
            box_idx_reg  <= box_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        row_reg        <= row_next;
        row_last_reg   <= row_last_next;
        byte_reg       <= byte_next;
        byte_first_reg <= byte_first_next;
        byte_last_reg  <= byte_last_next;
        bit_first_reg  <= bit_first_next;
        bit_last_reg   <= bit_last_next;
        row_base_reg   <= row_base_next;
        p_addr_reg     <= p_addr_next;
        p_mask_reg     <= p_mask_next;
        result_reg     <= result_next;
    end

    // The walk never reads the byte that is being written back in the same cycle.
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("frame store read and write hit the same byte");

    a_write_follows_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg |-> $past(state_reg == ST_WALK))
        else $error("write-back without a preceding walk read");

    a_idle_no_pending_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !p_valid_reg)
        else $error("write-back still pending when a new command is taken");

    a_walk_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |->
            (byte_reg <= byte_last_reg && byte_reg >= byte_first_reg &&
             row_reg <= row_last_reg))
        else $error("box walk left its clipped range");

endmodule

`default_nettype wire

// ===== rtl/core/mono_framebuffer_draw_engine.sv =====
// Top level of the monochrome draw engine: stream ports, clip registers and result register.
// Depends on mfde_pkg and mfde_engine.
`default_nettype none

// Monochrome 1-bit-per-pixel draw engine. After reset the frame store is cleared by a
// pass that writes one byte per cycle (1024 bytes at the default 128 x 64 screen); no
// command is taken during that time, while clip register writes are taken throughout.
// Each command transfer returns exactly one result transfer. A draw command is taken,
// then each box (one, or four for an outline) gets a setup step in which it is clipped,
// then every frame-store byte that it touches after clipping is read and written back,
// and then the command finishes; all bytes go through the single read-modify-write path
// of the frame store. A read command reads the addressed byte and returns it; a read of
// a pixel off the screen or an unused opcode returns without a frame-store read. The
// next command is taken while a result still waits.

module mono_framebuffer_draw_engine (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // pos_x[9:0], pos_y[19:10], span_w[29:20], span_h[39:30], ink[40], zero fill.
    input  wire logic [mfde_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[2:0].
    input  wire logic [mfde_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // read_byte[7:0].
    output logic      [mfde_pkg::M_TDATA_W-1:0]  m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mfde_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mfde_pkg::COORD_W-1:0]    cfg_data
);

    mfde_pkg::clip_cfg_t cfg_reg, cfg_next;
    mfde_pkg::cmd_t      cmd;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg, out_data_next;
    logic       res_valid, res_ready;
    logic [7:0] res_data;

    assign cmd = '{
        opcode: s_tuser[2:0],
        pos_x:  s_tdata[9:0],
        pos_y:  s_tdata[19:10],
        span_w: s_tdata[29:20],
        span_h: s_tdata[39:30],
        ink:    s_tdata[40]
    };

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                mfde_pkg::CFG_CLIP_ENABLE: cfg_next.clip_enable = cfg_data[0];
                mfde_pkg::CFG_CLIP_X_MIN:  cfg_next.clip_x_min  = cfg_data;
                mfde_pkg::CFG_CLIP_X_MAX:  cfg_next.clip_x_max  = cfg_data;
                mfde_pkg::CFG_CLIP_Y_MIN:  cfg_next.clip_y_min  = cfg_data;
                mfde_pkg::CFG_CLIP_Y_MAX:  cfg_next.clip_y_max  = cfg_data;
                default: ;
            endcase
        end
    end

    mfde_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .cmd_valid(s_tvalid),
        .cmd_ready(s_tready),
        .cmd      (cmd),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_data (res_data)
    );

    // The result register frees the engine as soon as the result is handed over.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_ready) begin
            out_valid_next = res_valid;
            if (res_valid) begin
                out_data_next = res_data;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
